FILE: design/mouse_motion_accumulator_top_defines.svh
// assertion macros used by the mouse motion accumulator top level
`ifndef MOUSE_MOTION_ACCUMULATOR_TOP_DEFINES_SVH
`define MOUSE_MOTION_ACCUMULATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled while reset is low
`define MMA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, disabled while reset is low
`define MMA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MMA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define MMA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

FILE: design/mma_pkg.sv
// types and constants of the mouse motion accumulator
package mma_pkg;

    localparam int ACC_W   = 64;
    localparam int DELTA_W = 32;
    localparam int REP_W   = 16;

    // request codes
    localparam logic [2:0] REQ_MOTION     = 3'd0;
    localparam logic [2:0] REQ_BUTTON     = 3'd1;
    localparam logic [2:0] REQ_READ       = 3'd2;
    localparam logic [2:0] REQ_SET_ACTIVE = 3'd3;
    localparam logic [2:0] REQ_RESET      = 3'd4;

    // button codes
    localparam logic [1:0] BTN_LEFT  = 2'd0;
    localparam logic [1:0] BTN_RIGHT = 2'd1;

    localparam logic [1:0] BTN_RELEASED = 2'b11;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    localparam logic signed [REP_W-1:0] REP_MAX = 16'sh7fff;
    localparam logic signed [REP_W-1:0] REP_MIN = 16'sh8000;

    // accumulator limits beyond which the report clamps
    localparam logic signed [ACC_W-1:0] FULL_HI = 64'sd32767;
    localparam logic signed [ACC_W-1:0] FULL_LO = -64'sd32768;
    localparam logic signed [ACC_W-1:0] HALF_HI = 64'sd65535;
    localparam logic signed [ACC_W-1:0] HALF_LO = -64'sd65537;

    typedef struct packed {
        logic [2:0]                req_type;
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
        logic [1:0]                button_id;
        logic                      flag_bit;
    } t_in_item;

    typedef struct packed {
        logic signed [REP_W-1:0] x_report;
        logic signed [REP_W-1:0] y_report;
        logic [1:0]              button_bits;
    } t_out_item;

    // per-axis operation select, at most one of motion / clear / init is set
    typedef struct packed {
        logic motion;
        logic clear;
        logic init;
    } t_axis_ctl;

endpackage

FILE: design/mma_axis.sv
// one axis: saturating delta add, clamped report and clearing subtract
module mma_axis (
    input  logic signed [63:0] i_acc,
    input  logic signed [31:0] i_delta,
    input  logic               i_half,
    input  mma_pkg::t_axis_ctl i_ctl,
    output logic signed [63:0] o_acc_next,
    output logic signed [15:0] o_report
);
    import mma_pkg::*;

    logic [ACC_W:0]          w_sum;
    logic                    w_ovf;
    logic signed [ACC_W-1:0] w_sat;
    logic                    w_hi;
    logic                    w_lo;
    logic [17:0]             w_half_t;
    logic [REP_W-1:0]        w_in_rng;
    logic signed [ACC_W-1:0] w_amt;

    // 65-bit sum, overflow when the two top bits differ
    assign w_sum = {i_acc[ACC_W-1], i_acc} + {{(ACC_W-DELTA_W+1){i_delta[DELTA_W-1]}}, i_delta};
    assign w_ovf = w_sum[ACC_W] ^ w_sum[ACC_W-1];
    assign w_sat = w_ovf ? (w_sum[ACC_W] ? ACC_MIN : ACC_MAX) : w_sum[ACC_W-1:0];

    // clamp decisions taken on the accumulator itself
    assign w_hi = i_half ? (i_acc > HALF_HI) : (i_acc > FULL_HI);
    assign w_lo = i_half ? (i_acc < HALF_LO) : (i_acc < FULL_LO);

    // halving toward zero: bump odd negatives by one before the shift
    assign w_half_t = i_acc[17:0] + {17'd0, i_acc[ACC_W-1] & i_acc[0]};
    assign w_in_rng = i_half ? w_half_t[16:1] : i_acc[REP_W-1:0];

    assign o_report = w_hi ? REP_MAX : (w_lo ? REP_MIN : $signed(w_in_rng));

    assign w_amt = i_half ? {{(ACC_W-REP_W-1){o_report[REP_W-1]}}, o_report, 1'b0}
                          : {{(ACC_W-REP_W){o_report[REP_W-1]}}, o_report};

    always_comb begin
        if (i_ctl.init) begin
            o_acc_next = '0;
        end else if (i_ctl.motion) begin
            o_acc_next = w_sat;
        end else if (i_ctl.clear) begin
            o_acc_next = i_acc - w_amt;
        end else begin
            o_acc_next = i_acc;
        end
    end

endmodule

FILE: design/mouse_motion_accumulator_top.sv
// mouse motion accumulator top level: input register, state update, result register
//
// input channel: i_in_valid / o_in_stall carry one request transaction in
// i_in_data (motion, button, read status, set active, reset). output channel:
// o_out_valid / i_out_stall carry one report transaction per read request in
// o_out_data; other requests produce no transaction.
// a transaction lands in the input register, is executed there against the
// accumulators, button bits and active flag, and a read result is captured in
// the output register, which drives o_out_valid; throughput one request per
// cycle with no stall. the execute step is a 65-bit saturating add, clamp
// compares and a subtract per axis (mma_axis), so every request type, reads
// included, sustains one per cycle while the receiver takes reports. when the
// receiver stalls a pending report, the output register holds it; non-read
// requests keep flowing, and a read waiting in the input register raises
// o_in_stall until the output register frees up. half_scale is to be written
// through i_cfg_we / i_cfg_wdata only while the block is idle; the block itself
// does not enforce this. reset (i_rst_n low, synchronous) clears both
// accumulators, releases both buttons, drops the active flag, clears
// half_scale and empties both registers.
`include "mouse_motion_accumulator_top_defines.svh"

module mouse_motion_accumulator_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  mma_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output mma_pkg::t_out_item o_out_data,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata
);
    import mma_pkg::*;

    // input register
    logic       r_in_valid;
    t_in_item   r_in;

    // block state
    logic signed [ACC_W-1:0] r_x_acc;
    logic signed [ACC_W-1:0] r_y_acc;
    logic [1:0]              r_buttons;
    logic                    r_active;
    logic                    r_half;

    // result register
    logic       r_out_valid;
    t_out_item  r_out;

    logic [1:0]              n_btn;
    logic                    n_active;
    logic signed [ACC_W-1:0] n_x_acc;
    logic signed [ACC_W-1:0] n_y_acc;
    logic signed [REP_W-1:0] w_x_rep;
    logic signed [REP_W-1:0] w_y_rep;

    logic       w_is_read;
    logic       w_out_free;
    logic       w_fire;
    logic       w_init;
    logic [1:0] w_mask;
    t_axis_ctl  w_x_ctl;
    t_axis_ctl  w_y_ctl;

    assign w_is_read  = (r_in.req_type == REQ_READ);
    // output register can take a new report this cycle
    assign w_out_free = !r_out_valid || !i_out_stall;
    // a read may only execute if its report has somewhere to go
    assign w_fire     = r_in_valid && (!w_is_read || w_out_free);
    assign o_in_stall = r_in_valid && !w_fire;

    // deactivate and reset both reinitialize the axes and buttons
    assign w_init = (r_in.req_type == REQ_RESET)
                 || ((r_in.req_type == REQ_SET_ACTIVE) && !r_in.flag_bit);

    always_comb begin
        w_x_ctl.motion = w_fire && (r_in.req_type == REQ_MOTION) && r_active;
        w_x_ctl.clear  = w_fire && w_is_read && r_in.flag_bit;
        w_x_ctl.init   = w_fire && w_init;
        w_y_ctl        = w_x_ctl;
    end

    mma_axis u_x_axis (
        .i_acc      (r_x_acc),
        .i_delta    (r_in.dx),
        .i_half     (r_half),
        .i_ctl      (w_x_ctl),
        .o_acc_next (n_x_acc),
        .o_report   (w_x_rep)
    );

    mma_axis u_y_axis (
        .i_acc      (r_y_acc),
        .i_delta    (r_in.dy),
        .i_half     (r_half),
        .i_ctl      (w_y_ctl),
        .o_acc_next (n_y_acc),
        .o_report   (w_y_rep)
    );

    // button and active flag update
    always_comb begin
        n_btn     = r_buttons;
        n_active  = r_active;
        w_mask    = (r_in.button_id == BTN_LEFT) ? 2'b01 : 2'b10;
        case (r_in.req_type)
            REQ_BUTTON: begin
                // codes other than left and right are dropped
                if ((r_in.button_id == BTN_LEFT) || (r_in.button_id == BTN_RIGHT)) begin
                    if (r_in.flag_bit) begin
                        // a press only counts while active
                        if (r_active) begin
                            n_btn = r_buttons & ~w_mask;
                        end
                    end else begin
                        n_btn = r_buttons | w_mask;
                    end
                end
            end
            REQ_SET_ACTIVE: begin
                n_active = r_in.flag_bit;
                if (!r_in.flag_bit) begin
                    n_btn = BTN_RELEASED;
                end
            end
            REQ_RESET: begin
                // active flag survives a reset request
                n_btn = BTN_RELEASED;
            end
            default: begin
                n_btn = r_buttons;
            end
        endcase
    end

    // input register loads whenever it is empty or its transaction executes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (!o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_acc   <= '0;
            r_y_acc   <= '0;
            r_buttons <= BTN_RELEASED;
            r_active  <= 1'b0;
        end else if (w_fire) begin
            r_x_acc   <= n_x_acc;
            r_y_acc   <= n_y_acc;
            r_buttons <= n_btn;
            r_active  <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= 1'b0;
        end else if (i_cfg_we) begin
            r_half <= i_cfg_wdata;
        end
    end

    // result register: loaded by an executing read, emptied when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_is_read) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_fire && w_is_read) begin
            r_out.x_report    <= w_x_rep;
            r_out.y_report    <= w_y_rep;
            r_out.button_bits <= r_buttons;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `MMA_ASSERT_NXT(a_read_gives_report, i_clk, i_rst_n, w_fire && w_is_read, r_out_valid, "executed read left no report")
    `MMA_ASSERT_NXT(a_idle_motion_holds, i_clk, i_rst_n, w_fire && (r_in.req_type == REQ_MOTION) && !r_active, $stable(r_x_acc) && $stable(r_y_acc), "motion changed accumulators while inactive")
    `MMA_ASSERT_NXT(a_deactivate_clears, i_clk, i_rst_n, w_fire && (r_in.req_type == REQ_SET_ACTIVE) && !r_in.flag_bit, !r_active && (r_buttons == BTN_RELEASED) && (r_x_acc == '0) && (r_y_acc == '0), "deactivate did not reinitialize state")
    `MMA_ASSERT_IMP(a_stall_only_full, i_clk, i_rst_n, o_in_stall, r_in_valid && w_is_read && r_out_valid && i_out_stall, "input stalled without a blocked read")
    `MMA_ASSERT_NXT(a_release_sets_bit, i_clk, i_rst_n, w_fire && (r_in.req_type == REQ_BUTTON) && (r_in.button_id == BTN_LEFT) && !r_in.flag_bit, r_buttons[0], "release did not set left bit")

endmodule

FILE: verif/mouse_motion_accumulator_top_tb.sv
// self-checking testbench for the mouse motion accumulator top level
`timescale 1ns / 1ps

module mouse_motion_accumulator_top_tb;
    import mma_pkg::*;

    // request and button codes that the block must ignore
    localparam logic [2:0] REQ_UNKNOWN_LO = 3'd5;
    localparam logic [2:0] REQ_UNKNOWN_HI = 3'd7;
    localparam logic [1:0] BTN_SPARE_LO   = 2'd2;
    localparam logic [1:0] BTN_SPARE_HI   = 2'd3;

    // active-low bit of each button in button_bits
    localparam logic [1:0] BTN_LEFT_MASK  = 2'b01;
    localparam logic [1:0] BTN_RIGHT_MASK = 2'b10;

    localparam logic signed [DELTA_W-1:0] DELTA_MAX = 32'sh7fffffff;
    localparam logic signed [DELTA_W-1:0] DELTA_MIN = 32'sh80000000;

    // half mode divides the report by two and clears twice the report
    localparam logic signed [ACC_W-1:0] HALF_DIVISOR = 64'sd2;

    localparam int MAX_GAP      = 14;   // longest idle draw on either side
    localparam int DRAIN_CYCLES = 6;    // pipeline is two deep, allow some slack
    localparam int SINK_HOLDOFF = 300;  // long receiver stall to back up the block
    localparam int IDLE_LIMIT   = 2000; // cycles with no transaction before giving up

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_data;
    logic      i_cfg_we;
    logic      i_cfg_wdata;

    mouse_motion_accumulator_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // 20 ns clock
    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // predicted mouse state, updated as each request transaction is taken
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] acc_x;
    logic signed [ACC_W-1:0] acc_y;
    logic [1:0]              btn_bits;
    logic                    mouse_active;
    logic                    half_mode;

    t_out_item expected_reports[$];   // reports owed by the block, oldest first
    t_out_item want;
    int        failures = 0;

    // idling controls shared by the driver, the sink and the tests
    bit tx_fast = 1'b0;            // sender never idles
    bit rx_fast = 1'b0;            // receiver never stalls
    int sink_hold_cycles = 0;      // pending long stall request for the sink

    // 64-bit add of a 32-bit delta, pinned at the accumulator limits
    function automatic logic signed [ACC_W-1:0] add_pinned(input logic signed [ACC_W-1:0] acc,
                                                           input logic signed [DELTA_W-1:0] d);
        logic [ACC_W:0] sum;
        sum = {acc[ACC_W-1], acc} + {{(ACC_W-DELTA_W+1){d[DELTA_W-1]}}, d};
        if (sum[ACC_W] != sum[ACC_W-1])
            return sum[ACC_W] ? ACC_MIN : ACC_MAX;
        return sum[ACC_W-1:0];
    endfunction

    // reported value of one axis, halved toward zero in half mode, then clamped
    function automatic logic signed [REP_W-1:0] clamp_report(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] scaled;
        scaled = half_mode ? acc / HALF_DIVISOR : acc;
        if (scaled > FULL_HI)
            return REP_MAX;
        if (scaled < FULL_LO)
            return REP_MIN;
        return scaled[REP_W-1:0];
    endfunction

    // amount a clearing read takes out of the accumulator
    function automatic logic signed [ACC_W-1:0] cleared_amount(input logic signed [REP_W-1:0] r);
        logic signed [ACC_W-1:0] wide;
        wide = r;
        return half_mode ? wide * HALF_DIVISOR : wide;
    endfunction

    // accumulators to zero, both buttons released; active flag untouched
    task automatic clear_pointer;
        acc_x    = '0;
        acc_y    = '0;
        btn_bits = BTN_RELEASED;
    endtask

    // advance the predicted state by one accepted request, queue its report
    task automatic track_request(input t_in_item req);
        t_out_item  rep;
        logic [1:0] mask;
        case (req.req_type)
            REQ_MOTION: begin
                // motion only counts while active
                if (mouse_active) begin
                    acc_x = add_pinned(acc_x, req.dx);
                    acc_y = add_pinned(acc_y, req.dy);
                end
            end
            REQ_BUTTON: begin
                if (req.button_id == BTN_LEFT || req.button_id == BTN_RIGHT) begin
                    mask = (req.button_id == BTN_LEFT) ? BTN_LEFT_MASK : BTN_RIGHT_MASK;
                    // press needs the active flag, release never does
                    if (req.flag_bit) begin
                        if (mouse_active)
                            btn_bits = btn_bits & ~mask;
                    end else begin
                        btn_bits = btn_bits | mask;
                    end
                end
            end
            REQ_READ: begin
                rep.x_report    = clamp_report(acc_x);
                rep.y_report    = clamp_report(acc_y);
                rep.button_bits = btn_bits;
                if (req.flag_bit) begin
                    acc_x = acc_x - cleared_amount(rep.x_report);
                    acc_y = acc_y - cleared_amount(rep.y_report);
                end
                expected_reports.push_back(rep);
            end
            REQ_SET_ACTIVE: begin
                if (req.flag_bit) begin
                    mouse_active = 1'b1;
                end else begin
                    clear_pointer();
                    mouse_active = 1'b0;
                end
            end
            REQ_RESET: begin
                clear_pointer();
            end
            default: begin
                // unknown request codes leave everything alone
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // request driver: random idle, then hold the transaction until taken
    // ------------------------------------------------------------------
    task automatic send_request(input t_in_item req);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        // stall is sampled with the value the block saw at this edge
        do @(posedge i_clk); while (o_in_stall);
        track_request(req);
    endtask

    function automatic t_in_item make_req(input logic [2:0] kind,
                                          input logic signed [DELTA_W-1:0] dx,
                                          input logic signed [DELTA_W-1:0] dy,
                                          input logic [1:0] bid,
                                          input logic flag);
        t_in_item req;
        req.req_type  = kind;
        req.dx        = dx;
        req.dy        = dy;
        req.button_id = bid;
        req.flag_bit  = flag;
        return req;
    endfunction

    // mostly moderate deltas around the clamp points, some tiny, a few full range
    function automatic logic signed [DELTA_W-1:0] random_delta(input int span);
        int roll;
        roll = $urandom_range(0, 15);
        if (roll == 0)
            return $urandom;
        if (roll < 4)
            return int'($urandom_range(0, 6)) - 3;
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // weighted request mix: mostly motion, buttons and reads, some mode changes, resets and unknown codes
    function automatic t_in_item random_request(input int span);
        t_in_item req;
        int       pick;
        req.dx        = $urandom;
        req.dy        = $urandom;
        req.button_id = 2'($urandom_range(0, 3));
        req.flag_bit  = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 42) begin
            req.req_type = REQ_MOTION;
            req.dx       = random_delta(span);
            req.dy       = random_delta(span);
        end else if (pick < 58) begin
            req.req_type = REQ_BUTTON;
        end else if (pick < 85) begin
            req.req_type = REQ_READ;
        end else if (pick < 92) begin
            // keep the block active most of the time
            req.req_type = REQ_SET_ACTIVE;
            req.flag_bit = ($urandom_range(0, 3) != 0);
        end else if (pick < 96) begin
            req.req_type = REQ_RESET;
        end else begin
            req.req_type = 3'($urandom_range(REQ_UNKNOWN_LO, REQ_UNKNOWN_HI));
        end
        return req;
    endfunction

    // drop valid, let every owed report arrive, then let the pipe empty out
    task automatic wait_idle;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // register write, only with the block drained
    task automatic write_half_scale(input logic value);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        half_mode = value;
    endtask

    task automatic run_random_traffic(input int count, input int span);
        send_request(make_req(REQ_SET_ACTIVE, '0, '0, BTN_LEFT, 1'b1));
        for (int n = 0; n < count; n++)
            send_request(random_request(span));
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // full scale: inactive behavior, clamps, buttons, ignored codes, reset, deactivate
    task automatic test_full_scale_basics;
        send_request(make_req(REQ_READ, '0, '0, BTN_LEFT, 1'b0));
        // inactive: press and motion do nothing, release still allowed
        send_request(make_req(REQ_BUTTON, '0, '0, BTN_LEFT, 1'b1));
        send_request(make_req(REQ_BUTTON, '0, '0, BTN_RIGHT, 1'b0));
        send_request(make_req(REQ_MOTION, DELTA_MAX, DELTA_MIN, BTN_LEFT, 1'b0));
        send_request(make_req(REQ_READ, '0, '0, BTN_LEFT, 1'b1));
        send_request(make_req(REQ_SET_ACTIVE, '0, '0, BTN_LEFT, 1'b1));
        // one past each clamp point
        send_request(make_req(REQ_MOTION, 32'sd32768, -32'sd32769, BTN_LEFT, 1'b0));
        send_request(make_req(REQ_BUTTON, '0, '0, BTN_LEFT, 1'b1));
        send_request(make_req(REQ_BUTTON, '0, '0, BTN_RIGHT, 1'b1));
        send_request(make_req(REQ_BUTTON, '0, '0, BTN_SPARE_LO, 1'b0));
        send_request(make_req(REQ_BUTTON, '0, '0, BTN_SPARE_HI, 1'b0));
        send_request(make_req(REQ_READ, '0, '0, BTN_LEFT, 1'b1));
        send_request(make_req(REQ_READ, '0, '0, BTN_LEFT, 1'b0));
        send_request(make_req(REQ_BUTTON, '0, '0, BTN_LEFT, 1'b0));
        send_request(make_req(REQ_MOTION, DELTA_MAX, DELTA_MIN, BTN_RIGHT, 1'b1));
        send_request(make_req(REQ_UNKNOWN_LO, DELTA_MIN, DELTA_MAX, BTN_SPARE_HI, 1'b1));
        send_request(make_req(REQ_UNKNOWN_HI, DELTA_MIN, DELTA_MAX, BTN_SPARE_HI, 1'b0));
        send_request(make_req(REQ_READ, '0, '0, BTN_LEFT, 1'b1));
        // reset request keeps the block active
        send_request(make_req(REQ_RESET, '0, '0, BTN_LEFT, 1'b0));
        send_request(make_req(REQ_MOTION, -32'sd3, 32'sd3, BTN_LEFT, 1'b0));
        send_request(make_req(REQ_READ, '0, '0, BTN_LEFT, 1'b0));
        // deactivate wipes state, later presses are ignored
        send_request(make_req(REQ_SET_ACTIVE, '0, '0, BTN_LEFT, 1'b0));
        send_request(make_req(REQ_BUTTON, '0, '0, BTN_LEFT, 1'b1));
        send_request(make_req(REQ_READ, '0, '0, BTN_LEFT, 1'b0));
    endtask

    // half scale: clamp points, truncation toward zero, double clear
    task automatic test_half_scale_limits;
        write_half_scale(1'b1);
        send_request(make_req(REQ_SET_ACTIVE, '0, '0, BTN_LEFT, 1'b1));
        send_request(make_req(REQ_MOTION, 32'sd65535, -32'sd65537, BTN_LEFT, 1'b0));
        send_request(make_req(REQ_READ, '0, '0, BTN_LEFT, 1'b1));
        send_request(make_req(REQ_READ, '0, '0, BTN_LEFT, 1'b0));
        send_request(make_req(REQ_MOTION, 32'sd65536, -32'sd65538, BTN_LEFT, 1'b0));
        send_request(make_req(REQ_READ, '0, '0, BTN_LEFT, 1'b1));
        send_request(make_req(REQ_READ, '0, '0, BTN_LEFT, 1'b1));
        send_request(make_req(REQ_READ, '0, '0, BTN_LEFT, 1'b0));
    endtask

    task automatic test_random_full_scale;
        write_half_scale(1'b0);
        tx_fast = 1'b0;
        rx_fast = 1'b0;
        run_random_traffic(400, 40000);
    endtask

    task automatic test_random_half_scale;
        write_half_scale(1'b1);
        tx_fast = 1'b1;
        rx_fast = 1'b0;
        run_random_traffic(400, 80000);
    endtask

    // sink stalls for a long stretch while reads keep coming, block must back up
    task automatic test_receiver_holdoff;
        t_in_item req;
        tx_fast = 1'b1;
        sink_hold_cycles = SINK_HOLDOFF;
        send_request(make_req(REQ_SET_ACTIVE, '0, '0, BTN_LEFT, 1'b1));
        for (int n = 0; n < 60; n++) begin
            req = random_request(40000);
            if (n % 2 == 0)
                req.req_type = REQ_READ;
            send_request(req);
        end
        tx_fast = 1'b0;
    endtask

    task automatic test_random_back_to_back;
        write_half_scale(1'b0);
        tx_fast = 1'b1;
        rx_fast = 1'b1;
        run_random_traffic(350, 40000);
    endtask

    task automatic test_random_slow_sender;
        write_half_scale(1'b1);
        tx_fast = 1'b0;
        rx_fast = 1'b1;
        run_random_traffic(350, 80000);
    endtask

    // ------------------------------------------------------------------
    // report sink: random stalls per transaction, long hold when asked
    // ------------------------------------------------------------------
    initial begin : report_sink
        int gap;
        i_out_stall = 1'b0;
        forever begin
            if (sink_hold_cycles > 0) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
                repeat (sink_hold_cycles - 1) @(negedge i_clk);
                sink_hold_cycles = 0;
            end else begin
                gap = rx_fast ? 0 : $urandom_range(0, MAX_GAP);
                if (gap > 0) begin
                    @(negedge i_clk);
                    i_out_stall <= 1'b1;
                    repeat (gap - 1) @(negedge i_clk);
                end
            end
            @(negedge i_clk);
            i_out_stall <= 1'b0;
            // wait until a report transaction goes through
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // ------------------------------------------------------------------
    // report checker: each transaction against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_reports.size() == 0) begin
                failures++;
                $display("%0t: unexpected report x=%0d y=%0d buttons=%b", $time,
                         o_out_data.x_report, o_out_data.y_report, o_out_data.button_bits);
            end else begin
                want = expected_reports.pop_front();
                if (o_out_data.x_report !== want.x_report) begin
                    failures++;
                    $display("%0t: x_report expected %0d got %0d", $time,
                             want.x_report, o_out_data.x_report);
                end
                if (o_out_data.y_report !== want.y_report) begin
                    failures++;
                    $display("%0t: y_report expected %0d got %0d", $time,
                             want.y_report, o_out_data.y_report);
                end
                if (o_out_data.button_bits !== want.button_bits) begin
                    failures++;
                    $display("%0t: button_bits expected %b got %b", $time,
                             want.button_bits, o_out_data.button_bits);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long without any transaction on either channel
    // ------------------------------------------------------------------
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = 1'b0;
        // predicted state after reset: inactive, released, full scale
        clear_pointer();
        mouse_active = 1'b0;
        half_mode    = 1'b0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_full_scale_basics();
        test_half_scale_limits();
        test_random_full_scale();
        test_random_half_scale();
        test_receiver_holdoff();
        test_random_back_to_back();
        test_random_slow_sender();

        // every owed report in, then a final drain for anything stray
        wait_idle();
        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
